// ----- rtl/ppm_pkg.sv -----
// Package for the per-pixel temporal mode block.
// Holds the sequencer state type and the histogram constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

   localparam int NUM_CH    = 3;      // blue, green, red
   localparam int BIN_COUNT = 256;    // one bin per 8-bit value
   localparam int BIN_W     = 8;      // bin index width
   localparam int CNT_W     = 8;      // bin count width

   localparam logic [BIN_W-1:0] BIN_LAST = 8'd255;
   localparam logic [CNT_W-1:0] CNT_MAX  = 8'd255;

   typedef logic [BIN_W-1:0] sample_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,   // zero all bins after reset
      ST_IDLE     = 6'b000010,   // wait for a sample
      ST_BUMP     = 6'b000100,   // write back incremented counts
      ST_SCAN     = 6'b001000,   // read and zero bins, compare counts
      ST_SCAN_END = 6'b010000,   // compare the last bin
      ST_RESULT   = 6'b100000    // hold the result until taken
   } state_type;

   // Saturating increment of one bin count.
   function automatic count_type sat_inc(input count_type cnt);
      count_type res;
      res = (cnt == CNT_MAX) ? cnt : count_type'(cnt + 1'b1);
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ppm_if.sv -----
// Valid/ready channel interfaces for the per-pixel temporal mode block.
// Depends on ppm_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

interface ppm_req_if import ppm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type blue_sample;
   sample_type green_sample;
   sample_type red_sample;
   logic       last_sample;

   modport source (output valid, blue_sample, green_sample, red_sample, last_sample,
                   input ready);
   modport sink   (input valid, blue_sample, green_sample, red_sample, last_sample,
                   output ready);
endinterface

interface ppm_rsp_if import ppm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type blue_mode;
   sample_type green_mode;
   sample_type red_mode;

   modport source (output valid, blue_mode, green_mode, red_mode, input ready);
   modport sink   (input valid, blue_mode, green_mode, red_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/per_pixel_temporal_mode.sv -----
// Per-pixel temporal mode: three 256-bin histograms and a shared scan sequencer.
// Depends on ppm_pkg and the channel interfaces in ppm_if.sv.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel    Dir  Handshake             Payload
// ---------  ---  --------------------  ----------------------------------------------
// req_chan   in   valid/ready (sink)    blue_sample, green_sample, red_sample, last_sample
// rsp_chan   out  valid/ready (source)  blue_mode, green_mode, red_mode
//
// A sample transaction is one histogram memory read, then the saturating
// write-back through the separate write port.
// A last-sample transaction adds the bin scan: reading and zeroing all 256
// bins, the final compare in ST_SCAN_END, then the result register is shown.
// After reset a clearing pass zeroes all bins; req_chan.ready is low during
// it. rsp_chan stalls hold the result and keep req_chan.ready low.

module per_pixel_temporal_mode
   import ppm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ppm_req_if.sink   req_chan,
   ppm_rsp_if.source rsp_chan
);

   // Sequencer
   state_type  state_ff, state_in;
   sample_type idx_ff, idx_in;            // scan / clear bin pointer

   // Sample latched for the write-back
   sample_type addr_ff [NUM_CH];
   sample_type addr_in [NUM_CH];
   logic       last_ff, last_in;

   // Histogram memories, one per channel
   count_type  hist_mem   [NUM_CH][BIN_COUNT];
   count_type  rd_data_ff [NUM_CH];
   sample_type rd_addr    [NUM_CH];
   sample_type wr_addr    [NUM_CH];
   count_type  wr_data    [NUM_CH];
   logic       wr_en;

   // Compare stage: data of bin cmp_bin_ff sits in rd_data_ff
   logic       cmp_valid_ff, cmp_valid_in;
   sample_type cmp_bin_ff, cmp_bin_in;
   count_type  best_cnt_ff [NUM_CH];
   sample_type best_val_ff [NUM_CH];
   logic       best_clr;

   sample_type req_smp [NUM_CH];
   logic       req_acc;

   assign req_smp[0] = req_chan.blue_sample;
   assign req_smp[1] = req_chan.green_sample;
   assign req_smp[2] = req_chan.red_sample;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = (state_ff == ST_RESULT);
   assign rsp_chan.blue_mode  = best_val_ff[0];
   assign rsp_chan.green_mode = best_val_ff[1];
   assign rsp_chan.red_mode   = best_val_ff[2];

   // Next state and memory port control
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      wr_en        = 1'b0;
      best_clr     = 1'b0;
      cmp_valid_in = 1'b0;
      cmp_bin_in   = idx_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rd_addr[ch] = (state_ff == ST_IDLE) ? req_smp[ch] : idx_ff;
         wr_addr[ch] = idx_ff;
         wr_data[ch] = '0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == BIN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // read is issued on the accept edge, address straight from the port
            if (req_acc) begin
               addr_in  = req_smp;
               last_in  = req_chan.last_sample;
               state_in = ST_BUMP;
            end
         end
         ST_BUMP: begin
            wr_en = 1'b1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
               wr_addr[ch] = addr_ff[ch];
               wr_data[ch] = sat_inc(rd_data_ff[ch]);
            end
            if (last_ff) begin
               best_clr = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // old count is read while the bin is zeroed for the next pixel
            wr_en        = 1'b1;
            cmp_valid_in = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == BIN_LAST) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      last_ff    <= last_in;
      cmp_bin_ff <= cmp_bin_in;
   end

   // Histogram memories: one write and one registered read per channel
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (wr_en) begin
            hist_mem[ch][wr_addr[ch]] <= wr_data[ch];
         end
         rd_data_ff[ch] <= hist_mem[ch][rd_addr[ch]];
      end
   end

   // Compare per channel: strictly greater keeps the smaller value on ties
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (best_clr) begin
            best_cnt_ff[ch] <= '0;
            best_val_ff[ch] <= '0;
         end else if (cmp_valid_ff && (rd_data_ff[ch] > best_cnt_ff[ch])) begin
            best_cnt_ff[ch] <= rd_data_ff[ch];
            best_val_ff[ch] <= cmp_bin_ff;
         end
      end
   end

`ifndef SYNTHESIS
   // a result and a new transaction never overlap
   a_rsp_excl_req: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("result pending while input ready");

   // every accepted transaction is written back in the next cycle
   a_acc_bump: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_BUMP))
      else $error("accepted transaction not written back");

   // a last sample starts the scan right after its write-back
   a_last_scan: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.last_sample) |=> ##1 (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("last sample did not start the scan");

   // compare data is valid exactly after a scan read
   a_cmp_valid: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("compare stage out of step with scan");
`endif

endmodule

`default_nettype wire
